[rtl/core/dcmf_pkg.sv]
// ----------------------------------------------------------------------------
// dcmf_pkg: shared constants for the dark channel minimum filter
// Register codes, reset values, default limits and the colour minimum.
// ----------------------------------------------------------------------------
package dcmf_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_WINDOW = 31;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic [11:0] RESET_FRAME_WIDTH  = 12'd640;
    localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd480;
    localparam logic [4:0]  RESET_WINDOW_SIZE  = 5'd15;

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] x,
                                              input logic [PIX_W-1:0] y,
                                              input logic [PIX_W-1:0] z);
        logic [PIX_W-1:0] m;
        m = (x < y) ? x : y;
        if (z < m) m = z;
        return m;
    endfunction

endpackage

[rtl/core/dark_channel_min_filter_top.sv]
// ----------------------------------------------------------------------------
// dark_channel_min_filter_top: dark channel minimum filter
// Per-pixel BGR minimum, then a square window minimum in raster order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata {red,green,blue}, tuser flush
//  m_*      out  m_tvalid/m_tready    tdata dark_value, tlast frame_last
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
//  Scan: a beat that yields a result is a job for the scan engine, which
//  steps setup, address, scan (one line store read per pixel of the window,
//  clipped at the frame border), finish and emit; the single read port of
//  the line store sets its pace. A two-job queue and the output register
//  let intake run ahead while a result waits on m_tready.
//  Reset: synchronous, active low; registers return to 640x480, window 15.
//  The line store is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module dark_channel_min_filter_top #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = dcmf_pkg::DEF_MAX_WINDOW
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] blue, [15:8] green, [23:16] red
    input  logic        s_tuser,    // [0] flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] dark_value
    output logic        m_tlast,    // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = AW + RW + CW + 1;

    // config registers, raw as written
    logic [11:0] fw_reg, fw_next;
    logic [12:0] fh_reg, fh_next;
    logic [4:0]  ws_reg, ws_next;
    logic        restart;

    // effective (saturated) geometry
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [SW-1:0] s_eff, a_len, b_len;

    // front <-> queue <-> back
    logic          q_push, q_full, q_pop, q_valid, back_busy;
    logic [JW-1:0] f_job, q_job;
    logic [1:0]    q_count;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        ws_next = ws_reg;
        restart = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                dcmf_pkg::CFG_FRAME_WIDTH: begin
                    fw_next = cfg_wdata[11:0];
                    restart = 1'b1;
                end
                dcmf_pkg::CFG_FRAME_HEIGHT: begin
                    fh_next = cfg_wdata;
                    restart = 1'b1;
                end
                dcmf_pkg::CFG_WINDOW_SIZE: begin
                    ws_next = cfg_wdata[4:0];
                    restart = 1'b1;
                end
                default: restart = 1'b0;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= dcmf_pkg::RESET_FRAME_WIDTH;
            fh_reg <= dcmf_pkg::RESET_FRAME_HEIGHT;
            ws_reg <= dcmf_pkg::RESET_WINDOW_SIZE;
        end else begin
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            ws_reg <= ws_next;
        end
    end

    // zero acts as one; above the build limit saturates
    always_comb begin
        if (fw_reg == 12'd0)                       w_eff = WW'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))     w_eff = WW'(MAX_WIDTH);
        else                                       w_eff = WW'(fw_reg);
        if (fh_reg == 13'd0)                       h_eff = HW'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))    h_eff = HW'(MAX_HEIGHT);
        else                                       h_eff = HW'(fh_reg);
        if (ws_reg == 5'd0)                        s_eff = SW'(1);
        else if (32'(ws_reg) > 32'(MAX_WINDOW))    s_eff = SW'(MAX_WINDOW);
        else                                       s_eff = SW'(ws_reg);
        a_len = s_eff >> 1;                        // rows/cols before anchor
        b_len = s_eff - SW'(1) - a_len;            // rows/cols after anchor
    end

    dcmf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .b_len   (b_len),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .push    (q_push),
        .job     (f_job),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dcmf_queue #(
        .W(JW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .din      (f_job),
        .full     (q_full),
        .pop      (q_pop),
        .dout     (q_job),
        .not_empty(q_valid),
        .count    (q_count)
    );

    dcmf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .a_len   (a_len),
        .b_len   (b_len),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (back_busy),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // queue occupancy never goes past its two slots
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3)
        else $error("job queue overflow");

    // intake stalls exactly when the queue is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (q_count != 2'd2))
        else $error("s_tready out of step with queue fill");

    // an idle scan engine picks up a waiting job in the next cycle
    a_back_pickup: assert property (@(posedge aclk) disable iff (!aresetn)
        (!back_busy && q_count != 2'd0) |=> back_busy)
        else $error("scan engine left a job waiting");

endmodule

[rtl/core/dcmf_queue.sv]
// ----------------------------------------------------------------------------
// dcmf_queue: two-entry job queue
// Decouples the pixel front end from the window scan engine.
// ----------------------------------------------------------------------------
module dcmf_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         not_empty,
    output logic [1:0]   count
);

    logic [W-1:0] slot_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign dout      = slot_reg[rptr_reg];
    assign count     = cnt_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wptr_next = do_push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 2'd1;
        if (!do_push && do_pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wptr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[rtl/core/dcmf_front.sv]
// ----------------------------------------------------------------------------
// dcmf_front: pixel intake and output scheduling
// Stores per-pixel minima, tracks raster positions and issues window jobs.
// ----------------------------------------------------------------------------
module dcmf_front #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = dcmf_pkg::DEF_MAX_WINDOW,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int SW    = $clog2(MAX_WINDOW + 1),
    localparam int DEPTH = MAX_WIDTH * MAX_WINDOW,
    localparam int AW    = $clog2(DEPTH),
    localparam int JW    = AW + RW + CW + 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic [WW-1:0]              w_eff,
    input  logic [HW-1:0]              h_eff,
    input  logic [SW-1:0]              b_len,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [3*dcmf_pkg::PIX_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       q_full,
    output logic                       push,
    output logic [JW-1:0]              job,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [dcmf_pkg::PIX_W-1:0] wr_data
);

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic          in_done_reg, in_done_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [AW-1:0] out_addr_reg, out_addr_next;

    logic          accept, store, col_wrap, ready_out, out_last;
    logic [CW:0]   col_inc;
    logic [HW-1:0] row_inc, hm1, need_r;
    logic [HW:0]   nr_sum;
    logic [CW:0]   nc_sum, wm1, need_c;
    logic [AW:0]   wa_inc, oa_inc;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign store    = accept && !s_tuser && !in_done_reg;
    assign wr_en    = store;
    assign wr_addr  = wr_addr_reg;
    assign wr_data  = dcmf_pkg::min3(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);

    assign hm1 = h_eff - HW'(1);
    assign wm1 = (CW+1)'(w_eff) - (CW+1)'(1);

    always_comb begin
        col_inc  = (CW+1)'(in_col_reg) + (CW+1)'(1);
        col_wrap = (col_inc == (CW+1)'(w_eff));
        row_inc  = in_row_reg + HW'(1);
        wa_inc   = (AW+1)'(wr_addr_reg) + (AW+1)'(1);
        oa_inc   = (AW+1)'(out_addr_reg) + (AW+1)'(1);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        wr_addr_next = wr_addr_reg;
        if (store) begin
            in_col_next  = col_wrap ? '0 : CW'(col_inc);
            in_row_next  = col_wrap ? row_inc : in_row_reg;
            in_done_next = col_wrap && (row_inc == h_eff);
            wr_addr_next = (wa_inc == (AW+1)'(DEPTH)) ? '0 : AW'(wa_inc);
        end

        // last input row/column the output window still waits for
        nr_sum = (HW+1)'(out_row_reg) + (HW+1)'(b_len);
        need_r = (nr_sum > (HW+1)'(hm1)) ? hm1 : HW'(nr_sum);
        nc_sum = (CW+1)'(out_col_reg) + (CW+1)'(b_len);
        need_c = (nc_sum > wm1) ? wm1 : nc_sum;

        ready_out = in_done_next || (in_row_next > need_r) ||
                    ((in_row_next == need_r) && ((CW+1)'(in_col_next) > need_c));
        out_last  = (out_row_reg == RW'(hm1)) && ((CW+1)'(out_col_reg) == wm1);
        push      = accept && ready_out;
        job       = {out_last, out_row_reg, out_col_reg, out_addr_reg};

        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_addr_next = out_addr_reg;
        if (push) begin
            out_addr_next = (oa_inc == (AW+1)'(DEPTH)) ? '0 : AW'(oa_inc);
            if ((CW+1)'(out_col_reg) == wm1) begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
        end

        // frame end or register write: back to the top of the frame
        if (restart || (push && out_last)) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_done_next  = 1'b0;
            wr_addr_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_done_reg  <= 1'b0;
            wr_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_done_reg  <= in_done_next;
            wr_addr_reg  <= wr_addr_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_addr_reg <= out_addr_next;
        end
    end

endmodule

[rtl/core/dcmf_back.sv]
// ----------------------------------------------------------------------------
// dcmf_back: window scan engine
// Holds the line store, scans the clipped window and drives the result.
// ----------------------------------------------------------------------------
module dcmf_back #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = dcmf_pkg::DEF_MAX_WINDOW,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int SW    = $clog2(MAX_WINDOW + 1),
    localparam int DEPTH = MAX_WIDTH * MAX_WINDOW,
    localparam int AW    = $clog2(DEPTH),
    localparam int JW    = AW + RW + CW + 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [WW-1:0]              w_eff,
    input  logic [HW-1:0]              h_eff,
    input  logic [SW-1:0]              a_len,
    input  logic [SW-1:0]              b_len,
    input  logic                       q_valid,
    input  logic [JW-1:0]              q_job,
    output logic                       q_pop,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [dcmf_pkg::PIX_W-1:0] wr_data,
    output logic                       busy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dcmf_pkg::PIX_W-1:0] m_tdata,
    output logic                       m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [dcmf_pkg::PIX_W-1:0] mem [DEPTH];

    logic [2:0]    state_reg, state_next;
    logic [JW-1:0] job_reg, job_next;
    logic [AW:0]   offset_reg, offset_next;
    logic [SW-1:0] row_span_reg, row_span_next, col_span_reg, col_span_next;
    logic [SW-1:0] x_reg, x_next, y_reg, y_next;
    logic [AW-1:0] addr_reg, addr_next, base_reg, base_next;
    logic [dcmf_pkg::PIX_W-1:0] best_reg, best_next, rd_data_reg;
    logic          rd_en, rd_vld_reg;
    logic          m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [dcmf_pkg::PIX_W-1:0] m_data_reg, m_data_next;

    logic [AW-1:0] j_addr;
    logic [CW-1:0] j_col;
    logic [RW-1:0] j_row;
    logic          j_last;
    logic [SW-1:0] ys, ye, xs, xe;
    logic [RW-1:0] rows_below;
    logic [CW-1:0] cols_right;
    logic [SW+WW-1:0] prod;
    logic [AW:0]   start_sum, a_inc, b_inc;

    assign {j_last, j_row, j_col, j_addr} = job_reg;
    assign busy     = (state_reg != ST_IDLE);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign rd_en    = (state_reg == ST_SCAN);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[addr_reg];
    end

    always_comb begin
        // clipped window extent around the output pixel
        rows_below = RW'(h_eff - HW'(1)) - j_row;
        cols_right = CW'(w_eff - WW'(1)) - j_col;
        ys = ((RW+SW)'(j_row) > (RW+SW)'(a_len)) ? a_len : SW'(j_row);
        ye = ((RW+SW)'(rows_below) > (RW+SW)'(b_len)) ? b_len : SW'(rows_below);
        xs = ((CW+SW)'(j_col) > (CW+SW)'(a_len)) ? a_len : SW'(j_col);
        xe = ((CW+SW)'(cols_right) > (CW+SW)'(b_len)) ? b_len : SW'(cols_right);
        prod = {{WW{1'b0}}, ys} * {{SW{1'b0}}, w_eff};

        start_sum = (AW+1)'(j_addr) + (AW+1)'(DEPTH) - offset_reg;
        a_inc     = (AW+1)'(addr_reg) + (AW+1)'(1);
        b_inc     = (AW+1)'(base_reg) + (AW+1)'(w_eff);

        state_next    = state_reg;
        job_next      = job_reg;
        offset_next   = offset_reg;
        row_span_next = row_span_reg;
        col_span_next = col_span_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        addr_next     = addr_reg;
        base_next     = base_reg;
        best_next     = best_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (rd_vld_reg && (rd_data_reg < best_reg)) best_next = rd_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    job_next   = q_job;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                offset_next   = (AW+1)'(prod) + (AW+1)'(xs);
                row_span_next = ys + ye;
                col_span_next = xs + xe;
                state_next    = ST_ADDR;
            end
            ST_ADDR: begin
                addr_next  = (start_sum >= (AW+1)'(DEPTH)) ?
                             AW'(start_sum - (AW+1)'(DEPTH)) : AW'(start_sum);
                base_next  = addr_next;
                x_next     = '0;
                y_next     = '0;
                best_next  = '1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (x_reg == col_span_reg) begin
                    x_next    = '0;
                    y_next    = y_reg + SW'(1);
                    base_next = (b_inc >= (AW+1)'(DEPTH)) ?
                                AW'(b_inc - (AW+1)'(DEPTH)) : AW'(b_inc);
                    addr_next = base_next;
                    if (y_reg == row_span_reg) state_next = ST_FIN;
                end else begin
                    x_next    = x_reg + SW'(1);
                    addr_next = (a_inc == (AW+1)'(DEPTH)) ? '0 : AW'(a_inc);
                end
            end
            ST_FIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = best_reg;
                    m_last_next  = j_last;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        offset_reg   <= offset_next;
        row_span_reg <= row_span_next;
        col_span_reg <= col_span_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        addr_reg     <= addr_next;
        base_reg     <= base_next;
        best_reg     <= best_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
